// ===== hdl/rgbycc_pkg.sv =====
package rgbycc_pkg;

    localparam int PIX_W    = 8;
    localparam int SAMPLE_W = 9;

    // Matrix products and pair sums fit 25 bits signed; the partial holds one product
    localparam int SUM_W  = 25;
    localparam int PART_W = 24;

    localparam int PRECISION_SHIFT_DEF = 1;
    localparam int CHROMA_SHIFT_BASE   = 17;
    localparam int LUMA_FRAC_W         = 16;
    // -128 + 16 folded into one offset
    localparam int LUMA_OFFSET         = 112;

    typedef logic [PIX_W-1:0]           t_pix;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [PART_W-1:0]   t_part;

    localparam t_sum Y_R  = 25'sd16828;
    localparam t_sum Y_G  = 25'sd33038;
    localparam t_sum Y_B  = 25'sd6416;
    localparam t_sum CR_R = 25'sd28784;
    localparam t_sum CR_G = -25'sd24121;
    localparam t_sum CR_B = -25'sd4663;
    localparam t_sum CB_R = -25'sd9729;
    localparam t_sum CB_G = -25'sd19055;
    localparam t_sum CB_B = 25'sd28784;

    localparam t_sum SAT_HI = 25'sd255;
    localparam t_sum SAT_LO = -25'sd256;

    function automatic t_sample sat9(input t_sum v);
        t_sample res;
        if (v > SAT_HI) begin
            res = t_sample'(SAT_HI);
        end else if (v < SAT_LO) begin
            res = t_sample'(SAT_LO);
        end else begin
            res = $signed(v[SAMPLE_W-1:0]);
        end
        return res;
    endfunction

endpackage

// ===== hdl/rgbycc_if.sv =====
interface rgbycc_pix_if;
    logic                 valid;
    logic                 ready;
    rgbycc_pkg::t_pix     red;
    rgbycc_pkg::t_pix     green;
    rgbycc_pkg::t_pix     blue;
    logic                 end_of_frame;

    modport source (output valid, red, green, blue, end_of_frame, input ready);
    modport sink   (input valid, red, green, blue, end_of_frame, output ready);
endinterface

interface rgbycc_res_if;
    logic                 valid;
    logic                 ready;
    rgbycc_pkg::t_sample  luma;
    logic                 chroma_valid;
    rgbycc_pkg::t_sample  chroma_red;
    rgbycc_pkg::t_sample  chroma_blue;

    modport source (output valid, luma, chroma_valid, chroma_red, chroma_blue, input ready);
    modport sink   (input valid, luma, chroma_valid, chroma_red, chroma_blue, output ready);
endinterface

// ===== hdl/rgb_to_ycbcr_422_unit.sv =====
// Channel  | Dir | Payload
// i_pix    | in  | red, green, blue (8 bit), end_of_frame
// o_res    | out | luma (9 bit s), chroma_valid, chroma_red, chroma_blue (9 bit s)
//
// One item per clock while the result side is ready; each item passes the input register, then the result register.
// The colour matrix, pair sum and saturation sit between those two registers.
// Synchronous active-low reset empties both registers and restarts the pair phase.
// A stalled result holds the result register; the input register still advances
// in the same cycle that the result is taken, so no bubble appears.
module rgb_to_ycbcr_422_unit #(
    parameter int PRECISION_SHIFT = rgbycc_pkg::PRECISION_SHIFT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rgbycc_pix_if.sink         i_pix,
    rgbycc_res_if.source       o_res
);

    localparam int Y_W      = rgbycc_pkg::PIX_W + 1 + PRECISION_SHIFT;
    localparam int CHROMA_SH = rgbycc_pkg::CHROMA_SHIFT_BASE - PRECISION_SHIFT;

    // input register
    logic                 r_a_valid;
    rgbycc_pkg::t_pix     r_red, r_green, r_blue;
    logic                 r_eof;

    // pair state
    logic                 r_phase;
    rgbycc_pkg::t_part    r_cr_part, r_cb_part;

    // result register
    logic                 r_out_valid;
    rgbycc_pkg::t_sample  r_out_luma, r_out_cr, r_out_cb;
    logic                 r_out_cv;

    logic                 in_acc;
    logic                 a_adv;

    rgbycc_pkg::t_sum     w_r, w_g, w_b;
    rgbycc_pkg::t_sum     y_sum, cr_px, cb_px, cr_pair, cb_pair;
    logic signed [Y_W-1:0] y_cent, y_scaled;
    rgbycc_pkg::t_sample  n_luma, n_cr, n_cb;

    assign a_adv       = r_a_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_a_valid || a_adv;
    assign in_acc      = i_pix.valid && i_pix.ready;

    assign w_r = rgbycc_pkg::SUM_W'($signed({1'b0, r_red}));
    assign w_g = rgbycc_pkg::SUM_W'($signed({1'b0, r_green}));
    assign w_b = rgbycc_pkg::SUM_W'($signed({1'b0, r_blue}));

    assign y_sum = rgbycc_pkg::Y_R * w_r + rgbycc_pkg::Y_G * w_g + rgbycc_pkg::Y_B * w_b;
    assign cr_px = rgbycc_pkg::CR_R * w_r + rgbycc_pkg::CR_G * w_g + rgbycc_pkg::CR_B * w_b;
    assign cb_px = rgbycc_pkg::CB_R * w_r + rgbycc_pkg::CB_G * w_g + rgbycc_pkg::CB_B * w_b;

    // drop the fraction, centre, then scale
    assign y_cent = Y_W'($signed({1'b0,
                        y_sum[rgbycc_pkg::LUMA_FRAC_W +: rgbycc_pkg::PIX_W]}))
                    - Y_W'(rgbycc_pkg::LUMA_OFFSET);
    assign y_scaled = y_cent <<< PRECISION_SHIFT;
    assign n_luma   = rgbycc_pkg::sat9(rgbycc_pkg::SUM_W'(y_scaled));

    assign cr_pair = cr_px + rgbycc_pkg::SUM_W'(r_cr_part);
    assign cb_pair = cb_px + rgbycc_pkg::SUM_W'(r_cb_part);
    assign n_cr    = rgbycc_pkg::sat9(cr_pair >>> CHROMA_SH);
    assign n_cb    = rgbycc_pkg::sat9(cb_pair >>> CHROMA_SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_red   <= i_pix.red;
            r_green <= i_pix.green;
            r_blue  <= i_pix.blue;
            r_eof   <= i_pix.end_of_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_cr_part <= '0;
            r_cb_part <= '0;
        end else if (a_adv) begin
            // end of frame restarts the pairing whatever the phase
            if (r_eof || r_phase) begin
                r_phase   <= 1'b0;
                r_cr_part <= '0;
                r_cb_part <= '0;
            end else begin
                r_phase   <= 1'b1;
                r_cr_part <= $signed(cr_px[rgbycc_pkg::PART_W-1:0]);
                r_cb_part <= $signed(cb_px[rgbycc_pkg::PART_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_out_luma <= n_luma;
            r_out_cv   <= r_phase;
            r_out_cr   <= r_phase ? n_cr : '0;
            r_out_cb   <= r_phase ? n_cb : '0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.luma         = r_out_luma;
    assign o_res.chroma_valid = r_out_cv;
    assign o_res.chroma_red   = r_out_cr;
    assign o_res.chroma_blue  = r_out_cb;

    a_partial_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_phase |-> (r_cr_part == '0) && (r_cb_part == '0))
        else $error("partial sums not clear at start of pair");

    a_eof_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_adv && r_eof |=> !r_phase)
        else $error("pair phase not restarted after end of frame");

    a_pair_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_adv && r_phase |=> r_out_valid && r_out_cv)
        else $error("second pixel of pair gave no chroma");

    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_cv |-> (r_out_cr == '0) && (r_out_cb == '0))
        else $error("chroma fields set without chroma_valid");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !a_adv |-> !i_pix.ready)
        else $error("input register open while its item is held");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int PREC             = rgbycc_pkg::PRECISION_SHIFT_DEF;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS      = 334;
    localparam int MAX_REPORTS      = 10;
    localparam int TAIL_CYCLES      = 8;

    localparam longint K_Y_R  = 16828;
    localparam longint K_Y_G  = 33038;
    localparam longint K_Y_B  = 6416;
    localparam longint K_CR_R = 28784;
    localparam longint K_CR_G = -24121;
    localparam longint K_CR_B = -4663;
    localparam longint K_CB_R = -9729;
    localparam longint K_CB_G = -19055;
    localparam longint K_CB_B = 28784;
    localparam longint Y_MID  = 128;
    localparam longint Y_FOOT = 16;

    typedef struct packed {
        rgbycc_pkg::t_pix red;
        rgbycc_pkg::t_pix green;
        rgbycc_pkg::t_pix blue;
        logic             eof;
    } t_pixel;

    typedef struct packed {
        rgbycc_pkg::t_sample luma;
        logic                chroma_valid;
        rgbycc_pkg::t_sample chroma_red;
        rgbycc_pkg::t_sample chroma_blue;
    } t_ycc;

    typedef struct packed {
        t_pixel px;
        logic   typed;
        t_ycc   want;
    } t_dir_row;

    localparam int DIR_ROWS = 22;

    // Rows with typed set carry a value read straight off the matrix; the rest are predicted
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{-9'sd224, 1'b0, 9'sd0,   9'sd0}},
        '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, '{9'sd212,  1'b1, 9'sd0,   9'sd0}},
        '{'{8'd255, 8'd0,   8'd0,   1'b0}, 1'b1, '{-9'sd94,  1'b0, 9'sd0,   9'sd0}},
        '{'{8'd255, 8'd0,   8'd0,   1'b0}, 1'b1, '{-9'sd94,  1'b1, 9'sd223, -9'sd76}},
        '{'{8'd0,   8'd0,   8'd255, 1'b0}, 1'b1, '{-9'sd176, 1'b0, 9'sd0,   9'sd0}},
        '{'{8'd0,   8'd0,   8'd255, 1'b0}, 1'b1, '{-9'sd176, 1'b1, -9'sd37, 9'sd223}},
        '{'{8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, '0},
        '{'{8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, '0},
        // end of frame on the first of a pair: no chroma, pairing restarts
        '{'{8'd255, 8'd0,   8'd0,   1'b1}, 1'b1, '{-9'sd94,  1'b0, 9'sd0,   9'sd0}},
        '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{-9'sd224, 1'b0, 9'sd0,   9'sd0}},
        '{'{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{9'sd212,  1'b1, 9'sd0,   9'sd0}},
        '{'{8'd0,   8'd255, 8'd255, 1'b0}, 1'b0, '0},
        '{'{8'd0,   8'd255, 8'd255, 1'b0}, 1'b0, '0},
        '{'{8'd255, 8'd255, 8'd0,   1'b0}, 1'b0, '0},
        '{'{8'd255, 8'd255, 8'd0,   1'b0}, 1'b0, '0},
        '{'{8'd255, 8'd0,   8'd0,   1'b0}, 1'b0, '0},
        '{'{8'd0,   8'd0,   8'd255, 1'b1}, 1'b0, '0},
        '{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, '{-9'sd224, 1'b0, 9'sd0,   9'sd0}},
        '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
        '{'{8'd170, 8'd85,  8'd170, 1'b0}, 1'b0, '0},
        '{'{8'd85,  8'd170, 8'd85,  1'b0}, 1'b0, '0},
        '{'{8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    rgbycc_pix_if pix_ch ();
    rgbycc_res_if res_ch ();

    rgb_to_ycbcr_422_unit #(
        .PRECISION_SHIFT(PREC)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch),
        .o_res  (res_ch)
    );

    t_ycc        ycc_q[$];
    int unsigned mismatches;
    int unsigned stall_cycles;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned hold_req;
    int unsigned hold_done;

    // Predictor state: chroma products of the first pixel of a pair
    longint cr_first;
    longint cb_first;
    bit     second_of_pair;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic rgbycc_pkg::t_sample clip9(input longint v);
        if (v > 255) begin
            return 9'sd255;
        end
        if (v < -256) begin
            return -9'sd256;
        end
        return rgbycc_pkg::t_sample'(v);
    endfunction

    function automatic t_ycc convert_pixel(input t_pixel px);
        longint r, g, b, ysum, cr, cb;
        t_ycc   res;
        r    = longint'(px.red);
        g    = longint'(px.green);
        b    = longint'(px.blue);
        ysum = K_Y_R * r + K_Y_G * g + K_Y_B * b;
        cr   = K_CR_R * r + K_CR_G * g + K_CR_B * b;
        cb   = K_CB_R * r + K_CB_G * g + K_CB_B * b;
        res.luma = clip9(((ysum >>> 16) - Y_MID + Y_FOOT) * (longint'(1) << PREC));
        if (!second_of_pair) begin
            res.chroma_valid = 1'b0;
            res.chroma_red   = '0;
            res.chroma_blue  = '0;
            cr_first         = cr;
            cb_first         = cb;
            second_of_pair   = 1'b1;
        end else begin
            // the shift scales and averages the pair in one go
            res.chroma_valid = 1'b1;
            res.chroma_red   = clip9((cr + cr_first) >>> (17 - PREC));
            res.chroma_blue  = clip9((cb + cb_first) >>> (17 - PREC));
            cr_first         = 0;
            cb_first         = 0;
            second_of_pair   = 1'b0;
        end
        if (px.eof) begin
            cr_first       = 0;
            cb_first       = 0;
            second_of_pair = 1'b0;
        end
        return res;
    endfunction

    function automatic rgbycc_pkg::t_pix rand_component();
        // lean on the extremes now and then
        if ($urandom_range(7) == 0) begin
            return $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return rgbycc_pkg::t_pix'($urandom_range(255));
    endfunction

    task automatic offer_pixel(input t_pixel px, input logic typed, input t_ycc want);
        t_ycc pred;
        while ($urandom_range(99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid        <= 1'b1;
        pix_ch.red          <= px.red;
        pix_ch.green        <= px.green;
        pix_ch.blue         <= px.blue;
        pix_ch.end_of_frame <= px.eof;
        @(posedge i_clk);
        while (!pix_ch.ready) begin
            @(posedge i_clk);
        end
        pred = convert_pixel(px);
        ycc_q.push_back(typed ? want : pred);
    endtask

    task automatic wait_drained();
        while (ycc_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Result side: random stalls, and a long hold-off whenever one is requested
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                res_ch.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                hold_done = hold_done + 1;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_ycc want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (ycc_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected item: luma %0d cv %0b cr %0d cb %0d",
                             res_ch.luma, res_ch.chroma_valid,
                             res_ch.chroma_red, res_ch.chroma_blue);
                end
            end else begin
                want = ycc_q.pop_front();
                if (res_ch.luma !== want.luma || res_ch.chroma_valid !== want.chroma_valid ||
                    res_ch.chroma_red !== want.chroma_red ||
                    res_ch.chroma_blue !== want.chroma_blue) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS) begin
                        $display({"mismatch: exp luma %0d cv %0b cr %0d cb %0d, ",
                                  "got %0d %0b %0d %0d"},
                                 want.luma, want.chroma_valid, want.chroma_red,
                                 want.chroma_blue, res_ch.luma, res_ch.chroma_valid,
                                 res_ch.chroma_red, res_ch.chroma_blue);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        int unsigned k, ph, sent, flen;
        t_pixel      px;
        mismatches     = 0;
        stall_cycles   = 0;
        src_idle_pct   = 0;
        sink_idle_pct  = 0;
        hold_req       = 0;
        hold_done      = 0;
        cr_first       = 0;
        cb_first       = 0;
        second_of_pair = 1'b0;

        i_rst_n             <= 1'b0;
        pix_ch.valid        <= 1'b0;
        pix_ch.red          <= '0;
        pix_ch.green        <= '0;
        pix_ch.blue         <= '0;
        pix_ch.end_of_frame <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            offer_pixel(dir_rows[k].px, dir_rows[k].typed, dir_rows[k].want);
        end
        pix_ch.valid <= 1'b0;
        wait_drained();

        for (ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 11 : (ph == 1) ? 46 : 0;
            sink_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 11 : 0;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // short frames, odd lengths included, so pairing restarts often
                flen = $urandom_range(20, 1);
                for (k = 0; k < flen; k++) begin
                    px.red   = rand_component();
                    px.green = rand_component();
                    px.blue  = rand_component();
                    px.eof   = (k == flen - 1);
                    offer_pixel(px, 1'b0, '0);
                    sent = sent + 1;
                    if (ph == 0 && sent == 120) begin
                        hold_req <= hold_req + 1;
                    end
                end
            end
            // hold the input until the pipeline has emptied
            pix_ch.valid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && ycc_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rgbycc_pkg.sv
hdl/rgbycc_if.sv
hdl/rgb_to_ycbcr_422_unit.sv
bench/tb.sv
